// ===== hdl/pbsa_pkg.sv =====
package pbsa_pkg;

    localparam int DEF_LAYERS_PER_POOL = 64;
    localparam int DEF_MAX_POOLS       = 8;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = 1;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_POOL  = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_LAYER = 2'd3;

    typedef enum logic [2:0]
    {
        OP_ALLOC,
        OP_RELEASE,
        OP_QUERY,
        OP_BAD_POOL,
        OP_BAD_LAYER
    } op_t;

    typedef struct packed
    {
        op_t        op;
        logic [3:0] pool;
        logic [5:0] layer;
    } cmd_t;

    typedef struct packed
    {
        logic [1:0] status;
        logic [5:0] granted;
        logic [6:0] used;
        logic       full;
    } res_t;

endpackage

// ===== hdl/pbsa_front.sv =====
module pbsa_front
    import pbsa_pkg::*;
#(
    parameter int LAYERS_PER_POOL = DEF_LAYERS_PER_POOL,
    parameter int MAX_POOLS       = DEF_MAX_POOLS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] action,
    input  logic [3:0] pool_id,
    input  logic [6:0] layer_index,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data,
    output logic       q_push,
    output cmd_t       q_cmd,
    input  logic       q_full
);

    logic [3:0] pools_in_use_reg;
    logic [3:0] pools_in_use_next;
    logic       bad_pool;
    logic       bad_layer;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign q_push    = push && !q_full;

    // a register above the pool count acts as the pool count
    assign bad_pool  = (pool_id >= pools_in_use_reg)
                    || (5'(pool_id) >= 5'(MAX_POOLS));
    assign bad_layer = (7'(layer_index) >= 7'(LAYERS_PER_POOL));

    always_comb
    begin
        pools_in_use_next = pools_in_use_reg;
        if (cfg_valid && cfg_ready)
        begin
            pools_in_use_next = cfg_data;
        end
    end

    always_comb
    begin
        q_cmd.pool  = pool_id;
        q_cmd.layer = layer_index[5:0];
        if (bad_pool)
        begin
            q_cmd.op = OP_BAD_POOL;
        end
        else
        begin
            case (action)
                ACT_ALLOC:   q_cmd.op = OP_ALLOC;
                ACT_RELEASE: q_cmd.op = bad_layer ? OP_BAD_LAYER : OP_RELEASE;
                default:     q_cmd.op = OP_QUERY;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pools_in_use_reg <= '0;
        end
        else
        begin
            pools_in_use_reg <= pools_in_use_next;
        end
    end

endmodule

// ===== hdl/pbsa_cmd_fifo.sv =====
module pbsa_cmd_fifo
    import pbsa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic q_full,
    input  logic rd_en,
    output cmd_t rd_cmd,
    output logic q_empty
);

    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    cmd_t               mem_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg;
    logic [CMDQ_AW-1:0] wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg;
    logic [CMDQ_AW-1:0] rd_ptr_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               do_wr;
    logic               do_rd;

    assign q_full  = (count_reg == CW'(CMDQ_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_cmd  = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0
                        : CMDQ_AW'(wr_ptr_reg + 1'b1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0
                        : CMDQ_AW'(rd_ptr_reg + 1'b1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/pbsa_back.sv =====
module pbsa_back
    import pbsa_pkg::*;
#(
    parameter int LAYERS_PER_POOL = DEF_LAYERS_PER_POOL,
    parameter int MAX_POOLS       = DEF_MAX_POOLS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    input  cmd_t q_cmd,
    output logic q_pop,
    output logic empty,
    input  logic pop,
    output res_t result
);

    localparam int POOL_W  = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
    localparam int LAYER_W = (LAYERS_PER_POOL > 1) ? $clog2(LAYERS_PER_POOL) : 1;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_OUT
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    cmd_t                       cmd_reg;
    cmd_t                       cmd_next;
    logic [LAYER_W-1:0]         scan_reg;
    logic [LAYER_W-1:0]         scan_next;
    res_t                       res_reg;
    res_t                       res_next;
    res_t                       out_reg;
    res_t                       out_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [LAYERS_PER_POOL-1:0] bitmap_reg [MAX_POOLS];
    logic [6:0]                 count_reg  [MAX_POOLS];

    logic [POOL_W-1:0]          pool_sel;
    logic [LAYER_W-1:0]         layer_sel;
    logic [LAYERS_PER_POOL-1:0] word;
    logic [6:0]                 cnt;
    logic                       pool_is_full;
    logic                       map_we;
    logic [LAYERS_PER_POOL-1:0] map_wdata;
    logic [6:0]                 cnt_wdata;

    assign pool_sel     = cmd_reg.pool[POOL_W-1:0];
    assign layer_sel    = cmd_reg.layer[LAYER_W-1:0];
    assign word         = bitmap_reg[pool_sel];
    assign cnt          = count_reg[pool_sel];
    assign pool_is_full = (cnt == 7'(LAYERS_PER_POOL));
    assign empty        = !out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        scan_next      = scan_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        map_we         = 1'b0;
        map_wdata      = word;
        cnt_wdata      = cnt;
        q_pop          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_next.status  = ST_OK;
                res_next.granted = '0;
                res_next.used    = cnt;
                res_next.full    = pool_is_full;
                state_next       = S_OUT;
                case (cmd_reg.op)
                    OP_BAD_POOL:
                    begin
                        res_next.status = ST_BAD_POOL;
                        res_next.used   = '0;
                        res_next.full   = 1'b0;
                    end
                    OP_BAD_LAYER:
                    begin
                        res_next.status = ST_BAD_LAYER;
                    end
                    OP_RELEASE:
                    begin
                        if (word[layer_sel])
                        begin
                            map_we               = 1'b1;
                            map_wdata[layer_sel] = 1'b0;
                            cnt_wdata            = 7'(cnt - 7'd1);
                            res_next.used        = 7'(cnt - 7'd1);
                            res_next.full        = 1'b0;
                        end
                    end
                    OP_ALLOC:
                    begin
                        if (pool_is_full)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            scan_next  = '0;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_SCAN:
            begin
                // one slot per cycle, lowest first; a free slot exists here
                if (!word[scan_reg])
                begin
                    map_we              = 1'b1;
                    map_wdata[scan_reg] = 1'b1;
                    cnt_wdata           = 7'(cnt + 7'd1);
                    res_next.status     = ST_OK;
                    res_next.granted    = 6'(scan_reg);
                    res_next.used       = 7'(cnt + 7'd1);
                    res_next.full       = (7'(cnt + 7'd1) == 7'(LAYERS_PER_POOL));
                    state_next          = S_OUT;
                end
                else
                begin
                    scan_next = LAYER_W'(scan_reg + 1'b1);
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_POOLS; i++)
            begin
                bitmap_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (map_we)
            begin
                bitmap_reg[pool_sel] <= map_wdata;
                count_reg[pool_sel]  <= cnt_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        scan_reg <= scan_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule

// ===== hdl/pooled_bitmap_slot_allocator.sv =====
// an accepted request passes through the command queue and the IDLE, EXEC and
// OUT states to the result register; an allocate also scans slots in SCAN
// one request is carried out at a time; throughput is set by the slot scan
// (one slot per cycle)
// a two-entry command queue accepts requests while the scan runs
// reset clears every occupancy bitmap and used count, and pools_in_use to 0
module pooled_bitmap_slot_allocator
    import pbsa_pkg::*;
#(
    parameter int LAYERS_PER_POOL = DEF_LAYERS_PER_POOL,
    parameter int MAX_POOLS       = DEF_MAX_POOLS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] action,
    input  logic [3:0] pool_id,
    input  logic [6:0] layer_index,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] status,
    output logic [5:0] granted_layer,
    output logic [6:0] used_count,
    output logic       pool_full,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data
);

    logic q_push;
    cmd_t q_wr_cmd;
    logic q_full;
    logic q_pop;
    cmd_t q_rd_cmd;
    logic q_empty;
    res_t result;

    pbsa_front #(
        .LAYERS_PER_POOL (LAYERS_PER_POOL),
        .MAX_POOLS       (MAX_POOLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .pool_id     (pool_id),
        .layer_index (layer_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .q_push      (q_push),
        .q_cmd       (q_wr_cmd),
        .q_full      (q_full)
    );

    pbsa_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_cmd  (q_wr_cmd),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_cmd  (q_rd_cmd),
        .q_empty (q_empty)
    );

    pbsa_back #(
        .LAYERS_PER_POOL (LAYERS_PER_POOL),
        .MAX_POOLS       (MAX_POOLS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_cmd   (q_rd_cmd),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    assign status        = result.status;
    assign granted_layer = result.granted;
    assign used_count    = result.used;
    assign pool_full     = result.full;

endmodule
